// ----- rtl/linear_solve_3x3_pivoting_top_defines.svh -----
// Assertion macros used by the checker file of the 3x3 solver.
`ifndef LINEAR_SOLVE_3X3_PIVOTING_TOP_DEFINES_SVH
`define LINEAR_SOLVE_3X3_PIVOTING_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LSP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("solver port check failed");

// Antecedent implies consequent in the next cycle.
`define LSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("solver port check failed");

`endif

// ----- rtl/lsp_pkg.sv -----
// Types, constants and helper functions of the 3x3 pivoting solver.
package lsp_pkg;

   localparam int WORD_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUO_W         = WORD_W + 1;
   localparam int DIV_LAT       = QUO_W + 2;
   localparam int MUL_LAT       = 2;
   localparam int EPS_W         = 16;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd16;
   localparam int N_ROWS        = 3;
   localparam int N_COLS        = 4;
   localparam int REQ_W         = WORD_W * N_ROWS * N_COLS;
   localparam int RSP_W         = WORD_W * N_ROWS;
   localparam int USER_W        = 2;
   localparam int USER_SING     = 0;
   localparam int USER_OVF      = 1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [WORD_W:0]          mag_type;

   // Augmented matrix, solution and flags of one request in flight.
   typedef struct packed {
      word_type [N_ROWS-1:0][N_COLS-1:0] m;
      word_type [N_ROWS-1:0]             x;
      logic                              sing;
      logic                              ovf;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   // State handed from one divider cell to the next.
   typedef struct packed {
      logic [WORD_W-1:0] rem;
      logic [QUO_W-1:0]  lo;
      logic [QUO_W-1:0]  q;
      logic [WORD_W-1:0] d;
      logic              neg;
      logic              big;
   } div_type;

   // Magnitude; the most negative value maps to 2^31.
   function automatic mag_type mag(input word_type v);
      mag_type r;
      r = v[WORD_W-1] ? (~{1'b1, v} + mag_type'(1)) : {1'b0, v};
      return r;
   endfunction

   // Pivot too small to use.
   function automatic logic too_small(input mag_type m, input logic [EPS_W-1:0] eps);
      logic r;
      r = (m == '0) || (m < mag_type'(eps));
      return r;
   endfunction

endpackage

// ----- rtl/lsp_div_cell.sv -----
// One restoring division step: produces one quotient bit per cycle while en is high.
module lsp_div_cell (
   input  logic              clock,
   input  logic              en,
   input  lsp_pkg::div_type  d_i,
   output lsp_pkg::div_type  d_o
);

   lsp_pkg::div_type        cell_in;
   lsp_pkg::div_type        cell_ff;
   logic [lsp_pkg::WORD_W:0] trial;
   logic                    ge;

   // Shift in the next numerator bit, subtract when it fits.
   always_comb begin
      trial   = {d_i.rem, d_i.lo[lsp_pkg::QUO_W-1]};
      ge      = trial >= {1'b0, d_i.d};
      cell_in = d_i;
      cell_in.rem = ge ? lsp_pkg::WORD_W'(trial - {1'b0, d_i.d})
                       : trial[lsp_pkg::WORD_W-1:0];
      cell_in.lo  = {d_i.lo[lsp_pkg::QUO_W-2:0], 1'b0};
      cell_in.q   = {d_i.q[lsp_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign d_o = cell_ff;

endmodule

// ----- rtl/lsp_div.sv -----
// Pipelined saturating fixed-point divider: (num * 2^FRAC_BITS) / den.
module lsp_div #(
   parameter int FRAC_BITS = lsp_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              en,
   input  lsp_pkg::word_type num,
   input  lsp_pkg::word_type den,
   output lsp_pkg::word_type q,
   output logic              ovf
);

   localparam int W  = lsp_pkg::WORD_W;
   localparam int QW = lsp_pkg::QUO_W;

   lsp_pkg::div_type  front_in;
   lsp_pkg::div_type  front_ff;
   lsp_pkg::div_type  chain [QW+1];
   logic [W-1:0]      magn;
   logic [W-1:0]      magd;
   logic [2*W-1:0]    scaled;
   logic [QW-1:0]     qq;
   lsp_pkg::word_type q_in;
   lsp_pkg::word_type q_ff;
   logic              ovf_in;
   logic              ovf_ff;

   // Prepare magnitudes, flag quotients of 2^33 and up.
   always_comb begin
      magn   = W'(lsp_pkg::mag(num));
      magd   = W'(lsp_pkg::mag(den));
      scaled = (2*W)'(magn) << FRAC_BITS;
      front_in.rem = W'(scaled >> QW);
      front_in.lo  = scaled[QW-1:0];
      front_in.q   = '0;
      front_in.d   = magd;
      front_in.neg = num[W-1] ^ den[W-1];
      front_in.big = (2*W)'(magn) >= ((2*W)'(magd) << (QW - FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign chain[0] = front_ff;

   // Chain of quotient-bit cells.
   for (genvar i = 0; i < QW; i++) begin : g_cell
      lsp_div_cell u_cell (
         .clock (clock),
         .en    (en),
         .d_i   (chain[i]),
         .d_o   (chain[i+1])
      );
   end

   // Apply sign and saturate.
   always_comb begin
      qq     = chain[QW].q;
      ovf_in = 1'b0;
      if (chain[QW].big) begin
         ovf_in = 1'b1;
         q_in   = chain[QW].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if (chain[QW].neg) begin
         if (qq > (QW'(1) << (W-1))) begin
            ovf_in = 1'b1;
            q_in   = {1'b1, {(W-1){1'b0}}};
         end else begin
            q_in = W'(~qq + QW'(1));
         end
      end else begin
         if (qq > QW'({1'b0, {(W-1){1'b1}}})) begin
            ovf_in = 1'b1;
            q_in   = {1'b0, {(W-1){1'b1}}};
         end else begin
            q_in = qq[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff   <= q_in;
         ovf_ff <= ovf_in;
      end
   end

   assign q   = q_ff;
   assign ovf = ovf_ff;

endmodule

// ----- rtl/lsp_mulsub.sv -----
// Two-stage saturating v - (a * b) / 2^FRAC_BITS, truncated toward zero.
module lsp_mulsub #(
   parameter int FRAC_BITS = lsp_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              en,
   input  lsp_pkg::word_type v,
   input  lsp_pkg::word_type a,
   input  lsp_pkg::word_type b,
   output lsp_pkg::word_type r,
   output logic              ovf
);

   localparam int W = lsp_pkg::WORD_W;

   logic signed [2*W-1:0] prod_ff;
   lsp_pkg::word_type     v_ff;
   logic signed [2*W-1:0] rnd;
   logic signed [2*W-1:0] sh;
   logic signed [2*W:0]   diff;
   lsp_pkg::word_type     r_in;
   lsp_pkg::word_type     r_ff;
   logic                  ovf_in;
   logic                  ovf_ff;

   // Register the product.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= $signed(a) * $signed(b);
         v_ff    <= v;
      end
   end

   // Scale down toward zero, subtract, saturate.
   always_comb begin
      rnd  = prod_ff[2*W-1] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : '0;
      sh   = (prod_ff + rnd) >>> FRAC_BITS;
      diff = $signed({{(W+1){v_ff[W-1]}}, v_ff}) - $signed({sh[2*W-1], sh});
      ovf_in = 1'b0;
      if (diff > $signed({{(W+2){1'b0}}, {(W-1){1'b1}}})) begin
         ovf_in = 1'b1;
         r_in   = {1'b0, {(W-1){1'b1}}};
      end else if (diff < $signed({{(W+2){1'b1}}, {(W-1){1'b0}}})) begin
         ovf_in = 1'b1;
         r_in   = {1'b1, {(W-1){1'b0}}};
      end else begin
         r_in = diff[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff   <= r_in;
         ovf_ff <= ovf_in;
      end
   end

   assign r   = r_ff;
   assign ovf = ovf_ff;

endmodule

// ----- rtl/lsp_delay.sv -----
// Delay line that carries a request and its valid bit alongside a unit.
module lsp_delay #(
   parameter int W     = lsp_pkg::ITEM_W,
   parameter int DEPTH = lsp_pkg::MUL_LAT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         vld_i,
   input  logic [W-1:0] dat_i,
   output logic         vld_o,
   output logic [W-1:0] dat_o
);

   logic [DEPTH-1:0] vld_ff;
   logic [W-1:0]     dat_ff [DEPTH];

   // Advance the valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], vld_i};
      end
   end

   // Advance the payload.
   always_ff @(posedge clock) begin
      if (en) begin
         dat_ff[0] <= dat_i;
         for (int i = 1; i < DEPTH; i++) begin
            dat_ff[i] <= dat_ff[i-1];
         end
      end
   end

   assign vld_o = vld_ff[DEPTH-1];
   assign dat_o = dat_ff[DEPTH-1];

endmodule

// ----- rtl/linear_solve_3x3_pivoting_top.sv -----
// Top level of the 3x3 fixed-point solver with partial pivoting.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_tvalid/req_tready | req_tdata: a00..a22, rhs0..rhs2
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: x0..x2; rsp_tuser flags
//  csr     | in        | csr_we                | csr_wdata: pivot_epsilon
//
//  One request per cycle while the pipeline does not hold; the path runs through
//  five dependent dividers of 33 bit cells each and four multiply stages.
//  Reset clears all valid bits and sets pivot_epsilon to 16.
//  The pipeline holds only when the output register is full, not taken, and the
//  last stage carries a result; otherwise requests keep entering.
module linear_solve_3x3_pivoting_top #(
   parameter int FRAC_BITS = lsp_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lsp_pkg::EPS_W-1:0]           csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a00,a01,a02,a10,a11,a12,a20,a21,a22,rhs0,rhs1,rhs2, 32 bits each, low first
   input  logic [lsp_pkg::REQ_W-1:0]           req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // x0,x1,x2, 32 bits each, low first
   output logic [lsp_pkg::RSP_W-1:0]           rsp_tdata,
   // singular (bit 0), overflow (bit 1)
   output logic [lsp_pkg::USER_W-1:0]          rsp_tuser
);

   localparam int W  = lsp_pkg::WORD_W;
   localparam int IW = lsp_pkg::ITEM_W;
   localparam int DL = lsp_pkg::DIV_LAT;
   localparam int ML = lsp_pkg::MUL_LAT;

   logic [lsp_pkg::EPS_W-1:0] eps_ff;
   logic                      en;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= lsp_pkg::EPS_RESET;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   // ---------------- column 0 pivot ----------------
   lsp_pkg::item_type raw;
   lsp_pkg::item_type s1_in;
   lsp_pkg::item_type s1_ff;
   logic              s1_vld_ff;
   lsp_pkg::mag_type  pm0;
   lsp_pkg::mag_type  pm1;
   lsp_pkg::mag_type  pm2;
   lsp_pkg::mag_type  pbest;
   logic [1:0]        best;

   always_comb begin
      raw = '0;
      for (int r = 0; r < lsp_pkg::N_ROWS; r++) begin
         for (int c = 0; c < lsp_pkg::N_ROWS; c++) begin
            raw.m[r][c] = req_tdata[(r*lsp_pkg::N_ROWS + c)*W +: W];
         end
         raw.m[r][lsp_pkg::N_ROWS] = req_tdata[(lsp_pkg::N_ROWS*lsp_pkg::N_ROWS + r)*W +: W];
      end
      pm0 = lsp_pkg::mag(raw.m[0][0]);
      pm1 = lsp_pkg::mag(raw.m[1][0]);
      pm2 = lsp_pkg::mag(raw.m[2][0]);
      best  = 2'd0;
      pbest = pm0;
      if (pm1 > pbest) begin
         best  = 2'd1;
         pbest = pm1;
      end
      if (pm2 > pbest) begin
         best  = 2'd2;
         pbest = pm2;
      end
      s1_in         = raw;
      s1_in.m[0]    = raw.m[best];
      s1_in.m[best] = raw.m[0];
      s1_in.sing    = lsp_pkg::too_small(pbest, eps_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- column 0 factors ----------------
   lsp_pkg::word_type f0 [1:2];
   logic              f0_ovf [1:2];
   logic [IW-1:0]     d0_dat;
   logic              d0_vld;
   lsp_pkg::item_type d0_item;
   lsp_pkg::item_type e0_in;

   for (genvar gr = 1; gr < 3; gr++) begin : g_div0
      lsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock), .en (en),
         .num (s1_ff.m[gr][0]), .den (s1_ff.m[0][0]),
         .q (f0[gr]), .ovf (f0_ovf[gr])
      );
   end

   lsp_delay #(.W(IW), .DEPTH(DL)) u_dly_d0 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (s1_vld_ff), .dat_i (s1_ff), .vld_o (d0_vld), .dat_o (d0_dat)
   );

   always_comb begin
      d0_item   = lsp_pkg::item_type'(d0_dat);
      e0_in     = d0_item;
      e0_in.ovf = d0_item.ovf | f0_ovf[1] | f0_ovf[2];
   end

   // ---------------- column 0 elimination ----------------
   lsp_pkg::word_type e0_res [1:2][1:3];
   logic              e0_ovf [1:2][1:3];
   logic [IW-1:0]     e0_dat;
   logic              e0_vld;
   lsp_pkg::item_type e0_item;

   for (genvar gr = 1; gr < 3; gr++) begin : g_row0
      for (genvar gc = 1; gc < 4; gc++) begin : g_col0
         lsp_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms (
            .clock (clock), .en (en),
            .v (d0_item.m[gr][gc]), .a (d0_item.m[0][gc]), .b (f0[gr]),
            .r (e0_res[gr][gc]), .ovf (e0_ovf[gr][gc])
         );
      end
   end

   lsp_delay #(.W(IW), .DEPTH(ML)) u_dly_e0 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (d0_vld), .dat_i (e0_in), .vld_o (e0_vld), .dat_o (e0_dat)
   );

   // ---------------- column 1 pivot ----------------
   lsp_pkg::item_type p1_in;
   lsp_pkg::item_type p1_ff;
   logic              p1_vld_ff;
   lsp_pkg::mag_type  q1m;
   lsp_pkg::mag_type  q2m;

   always_comb begin
      e0_item = lsp_pkg::item_type'(e0_dat);
      for (int r = 1; r < 3; r++) begin
         for (int c = 1; c < 4; c++) begin
            e0_item.m[r][c] = e0_res[r][c];
            e0_item.ovf     = e0_item.ovf | e0_ovf[r][c];
         end
      end
      q1m   = lsp_pkg::mag(e0_item.m[1][1]);
      q2m   = lsp_pkg::mag(e0_item.m[2][1]);
      p1_in = e0_item;
      if (q2m > q1m) begin
         p1_in.m[1] = e0_item.m[2];
         p1_in.m[2] = e0_item.m[1];
         p1_in.sing = e0_item.sing | lsp_pkg::too_small(q2m, eps_ff);
      end else begin
         p1_in.sing = e0_item.sing | lsp_pkg::too_small(q1m, eps_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= e0_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
      end
   end

   // ---------------- column 1 factor and elimination ----------------
   lsp_pkg::word_type f1;
   logic              f1_ovf;
   logic [IW-1:0]     d1_dat;
   logic              d1_vld;
   lsp_pkg::item_type d1_in;
   lsp_pkg::word_type e1_res [2:3];
   logic              e1_ovf [2:3];
   logic [IW-1:0]     e1_dat;
   logic              e1_vld;
   lsp_pkg::item_type e1_item;

   lsp_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
      .clock (clock), .en (en),
      .num (p1_ff.m[2][1]), .den (p1_ff.m[1][1]), .q (f1), .ovf (f1_ovf)
   );

   lsp_delay #(.W(IW), .DEPTH(DL)) u_dly_d1 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (p1_vld_ff), .dat_i (p1_ff), .vld_o (d1_vld), .dat_o (d1_dat)
   );

   always_comb begin
      d1_in     = lsp_pkg::item_type'(d1_dat);
      d1_in.ovf = d1_in.ovf | f1_ovf;
   end

   for (genvar gc = 2; gc < 4; gc++) begin : g_col1
      lsp_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms (
         .clock (clock), .en (en),
         .v (d1_in.m[2][gc]), .a (d1_in.m[1][gc]), .b (f1),
         .r (e1_res[gc]), .ovf (e1_ovf[gc])
      );
   end

   lsp_delay #(.W(IW), .DEPTH(ML)) u_dly_e1 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (d1_vld), .dat_i (d1_in), .vld_o (e1_vld), .dat_o (e1_dat)
   );

   // ---------------- column 2 pivot check ----------------
   lsp_pkg::item_type p2_in;
   lsp_pkg::item_type p2_ff;
   logic              p2_vld_ff;

   always_comb begin
      e1_item        = lsp_pkg::item_type'(e1_dat);
      e1_item.m[2][2] = e1_res[2];
      e1_item.m[2][3] = e1_res[3];
      e1_item.ovf    = e1_item.ovf | e1_ovf[2] | e1_ovf[3];
      p2_in          = e1_item;
      p2_in.sing     = e1_item.sing |
                       lsp_pkg::too_small(lsp_pkg::mag(e1_item.m[2][2]), eps_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= e1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff <= p2_in;
      end
   end

   // ---------------- x2 and first back-substitution terms ----------------
   lsp_pkg::word_type x2q;
   logic              x2_ovf;
   logic [IW-1:0]     d2_dat;
   logic              d2_vld;
   lsp_pkg::item_type b2_in;
   lsp_pkg::word_type acc1;
   lsp_pkg::word_type acc0a;
   logic              acc1_ovf;
   logic              acc0a_ovf;
   logic [IW-1:0]     b2_dat;
   logic              b2_vld;
   lsp_pkg::item_type b2_item;

   lsp_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
      .clock (clock), .en (en),
      .num (p2_ff.m[2][3]), .den (p2_ff.m[2][2]), .q (x2q), .ovf (x2_ovf)
   );

   lsp_delay #(.W(IW), .DEPTH(DL)) u_dly_d2 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (p2_vld_ff), .dat_i (p2_ff), .vld_o (d2_vld), .dat_o (d2_dat)
   );

   always_comb begin
      b2_in      = lsp_pkg::item_type'(d2_dat);
      b2_in.x[2] = x2q;
      b2_in.ovf  = b2_in.ovf | x2_ovf;
   end

   lsp_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_acc1 (
      .clock (clock), .en (en),
      .v (b2_in.m[1][3]), .a (b2_in.m[1][2]), .b (x2q), .r (acc1), .ovf (acc1_ovf)
   );

   lsp_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_acc0a (
      .clock (clock), .en (en),
      .v (b2_in.m[0][3]), .a (b2_in.m[0][2]), .b (x2q), .r (acc0a), .ovf (acc0a_ovf)
   );

   lsp_delay #(.W(IW), .DEPTH(ML)) u_dly_b2 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (d2_vld), .dat_i (b2_in), .vld_o (b2_vld), .dat_o (b2_dat)
   );

   always_comb begin
      b2_item         = lsp_pkg::item_type'(b2_dat);
      b2_item.m[1][3] = acc1;
      b2_item.m[0][3] = acc0a;
      b2_item.ovf     = b2_item.ovf | acc1_ovf | acc0a_ovf;
   end

   // ---------------- x1 and last term of row 0 ----------------
   lsp_pkg::word_type x1q;
   logic              x1_ovf;
   logic [IW-1:0]     d3_dat;
   logic              d3_vld;
   lsp_pkg::item_type b3_in;
   lsp_pkg::word_type acc0;
   logic              acc0_ovf;
   logic [IW-1:0]     b4_dat;
   logic              b4_vld;
   lsp_pkg::item_type b4_item;

   lsp_div #(.FRAC_BITS(FRAC_BITS)) u_div3 (
      .clock (clock), .en (en),
      .num (b2_item.m[1][3]), .den (b2_item.m[1][1]), .q (x1q), .ovf (x1_ovf)
   );

   lsp_delay #(.W(IW), .DEPTH(DL)) u_dly_d3 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (b2_vld), .dat_i (b2_item), .vld_o (d3_vld), .dat_o (d3_dat)
   );

   always_comb begin
      b3_in      = lsp_pkg::item_type'(d3_dat);
      b3_in.x[1] = x1q;
      b3_in.ovf  = b3_in.ovf | x1_ovf;
   end

   lsp_mulsub #(.FRAC_BITS(FRAC_BITS)) u_ms_acc0 (
      .clock (clock), .en (en),
      .v (b3_in.m[0][3]), .a (b3_in.m[0][1]), .b (x1q), .r (acc0), .ovf (acc0_ovf)
   );

   lsp_delay #(.W(IW), .DEPTH(ML)) u_dly_b4 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (d3_vld), .dat_i (b3_in), .vld_o (b4_vld), .dat_o (b4_dat)
   );

   always_comb begin
      b4_item         = lsp_pkg::item_type'(b4_dat);
      b4_item.m[0][3] = acc0;
      b4_item.ovf     = b4_item.ovf | acc0_ovf;
   end

   // ---------------- x0 ----------------
   lsp_pkg::word_type x0q;
   logic              x0_ovf;
   logic [IW-1:0]     d4_dat;
   logic              last_vld;
   lsp_pkg::item_type last_item;

   lsp_div #(.FRAC_BITS(FRAC_BITS)) u_div4 (
      .clock (clock), .en (en),
      .num (b4_item.m[0][3]), .den (b4_item.m[0][0]), .q (x0q), .ovf (x0_ovf)
   );

   lsp_delay #(.W(IW), .DEPTH(DL)) u_dly_d4 (
      .clock (clock), .reset (reset), .en (en),
      .vld_i (b4_vld), .dat_i (b4_item), .vld_o (last_vld), .dat_o (d4_dat)
   );

   always_comb begin
      last_item      = lsp_pkg::item_type'(d4_dat);
      last_item.x[0] = x0q;
      last_item.ovf  = last_item.ovf | x0_ovf;
   end

   // ---------------- output register ----------------
   logic                           out_vld_in;
   logic                           out_vld_ff;
   logic [lsp_pkg::RSP_W-1:0]      out_data_in;
   logic [lsp_pkg::RSP_W-1:0]      out_data_ff;
   logic [lsp_pkg::USER_W-1:0]     out_user_in;
   logic [lsp_pkg::USER_W-1:0]     out_user_ff;

   // Hold the pipeline only when a finished result would be lost.
   assign en = !(out_vld_ff && !rsp_tready && last_vld);

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_tready;
      if (en && last_vld) begin
         out_vld_in = 1'b1;
      end
      out_user_in = '0;
      if (last_item.sing) begin
         out_data_in                    = '0;
         out_user_in[lsp_pkg::USER_SING] = 1'b1;
      end else begin
         out_data_in                    = {last_item.x[2], last_item.x[1], last_item.x[0]};
         out_user_in[lsp_pkg::USER_OVF]  = last_item.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && last_vld) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ----- rtl/lsp_checker.sv -----
// Port-level checks of the 3x3 solver, bound to the top level.
`include "linear_solve_3x3_pivoting_top_defines.svh"

module lsp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [lsp_pkg::RSP_W-1:0]   rsp_tdata,
   input logic [lsp_pkg::USER_W-1:0]  rsp_tuser
);

   // A singular system reports zero unknowns and no overflow.
   `LSP_ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_tvalid && rsp_tuser[lsp_pkg::USER_SING], rsp_tdata == '0 && !rsp_tuser[lsp_pkg::USER_OVF])

   // Requests are refused only while a result waits at the output.
   `LSP_ASSERT_IMPLY(a_ready_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

   // A stalled result stays put.
   `LSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind linear_solve_3x3_pivoting_top lsp_checker u_lsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
